// File: sv/bsst_pkg.sv
// shared types and constants for the bounded set span tracker
// no dependencies; used by bsst_cell and bounded_set_span_tracker
package bsst_pkg;

	localparam int DATA_W  = 32;
	localparam int GAP_W   = 33;
	localparam int CAP_W   = 7;
	localparam int COUNT_W = 7;

	// all ones in the gap register means no gap seen yet
	localparam logic [GAP_W-1:0] GAP_NONE = {GAP_W{1'b1}};

	// transaction travelling down the cell chain
	typedef struct packed {
		logic              vld;
		logic              store;
		logic [DATA_W-1:0] value;
		logic [GAP_W-1:0]  gap;
	} token_t;

endpackage

// File: sv/bounded_set_span_tracker.sv
// Bounded set span tracker. Each input transaction carries one signed 32-bit
// value; it is stored if fewer than min(capacity, MAX_ENTRIES) values are held,
// otherwise rejected. Every transaction produces one result with the accept
// flag, the count held and the shortest and longest span (both 0 under two
// values). Values travel down a chain of MAX_ENTRIES cells, one cell per cycle,
// each cell holding one stored value; a new transaction can enter every cycle
// and its result passes through the cell chain and then the output register.
// The whole chain stalls while a result waits on m_axis_tready. The user must
// write capacity only while no transaction is in flight; the block itself does
// not enforce this. No clearing pass is needed after reset.
// depends on bsst_pkg and bsst_cell
module bounded_set_span_tracker #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        capacity_we,
	input  logic [6:0]  capacity,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // [0] accepted, [7:1] stored_count,
	                                   // [39:8] shortest_span, [71:40] longest_span
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int EXT_W = (CNT_W > bsst_pkg::COUNT_W) ? CNT_W : bsst_pkg::COUNT_W;
	localparam logic [EXT_W-1:0] MAX_C = EXT_W'(MAX_ENTRIES);
	localparam logic [CNT_W-1:0] TWO_C = CNT_W'(2);

	logic                         en;
	logic [bsst_pkg::CAP_W-1:0]   cap_q;
	logic [CNT_W-1:0]             held_q;
	logic [EXT_W-1:0]             held_ext;
	logic [EXT_W-1:0]             cap_ext;
	logic                         take;
	logic                         store_in;

	bsst_pkg::token_t             tok [MAX_ENTRIES+1];
	logic [CNT_W-1:0]             idx [MAX_ENTRIES+1];

	logic [bsst_pkg::DATA_W-1:0]  least_q;
	logic [bsst_pkg::DATA_W-1:0]  greatest_q;
	logic [bsst_pkg::GAP_W-1:0]   gap_q;
	logic                         out_vld_q;
	logic [71:0]                  out_data_q;

	bsst_pkg::token_t             tail;
	logic [CNT_W-1:0]             tail_idx;
	logic                         first;
	logic [bsst_pkg::DATA_W-1:0]  least_nxt;
	logic [bsst_pkg::DATA_W-1:0]  greatest_nxt;
	logic [bsst_pkg::GAP_W-1:0]   gap_nxt;
	logic [CNT_W-1:0]             cnt_after;
	logic [EXT_W-1:0]             cnt_ext;
	logic                         two_plus;
	logic [bsst_pkg::DATA_W-1:0]  longest;
	logic [bsst_pkg::DATA_W-1:0]  shortest;

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;
	assign take          = s_axis_tvalid && en;

	// admission decided at the head, count is exact there
	assign held_ext = EXT_W'(held_q);
	assign cap_ext  = EXT_W'(cap_q);
	assign store_in = (held_ext < cap_ext) && (held_ext < MAX_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (capacity_we) begin
			cap_q <= capacity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (take && store_in) begin
			held_q <= held_q + 1'b1;
		end
	end

	always_comb begin
		tok[0].vld   = take;
		tok[0].store = store_in;
		tok[0].value = s_axis_tdata;
		tok[0].gap   = bsst_pkg::GAP_NONE;
		idx[0]       = held_q;
	end

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		bsst_cell #(
			.CNT_W (CNT_W),
			.POS   (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.tok_in  (tok[g]),
			.idx_in  (idx[g]),
			.tok_out (tok[g+1]),
			.idx_out (idx[g+1])
		);
	end

	assign tail     = tok[MAX_ENTRIES];
	assign tail_idx = idx[MAX_ENTRIES];

	// fold the transaction leaving the chain into the running extremes
	always_comb begin
		first        = tail.store && (tail_idx == '0);
		least_nxt    = least_q;
		greatest_nxt = greatest_q;
		gap_nxt      = gap_q;
		if (tail.store) begin
			if (first || ($signed(tail.value) < $signed(least_q))) begin
				least_nxt = tail.value;
			end
			if (first || ($signed(tail.value) > $signed(greatest_q))) begin
				greatest_nxt = tail.value;
			end
			if (tail.gap < gap_q) begin
				gap_nxt = tail.gap;
			end
		end
		cnt_after = tail_idx + CNT_W'(tail.store);
		cnt_ext   = EXT_W'(cnt_after);
		two_plus  = cnt_after >= TWO_C;
		longest   = two_plus ? (greatest_nxt - least_nxt) : '0;
		shortest  = two_plus ? gap_nxt[bsst_pkg::DATA_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			least_q    <= '0;
			greatest_q <= '0;
			gap_q      <= bsst_pkg::GAP_NONE;
			out_vld_q  <= 1'b0;
		end else if (en) begin
			out_vld_q <= tail.vld;
			if (tail.vld) begin
				least_q    <= least_nxt;
				greatest_q <= greatest_nxt;
				gap_q      <= gap_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && tail.vld) begin
			out_data_q <= {longest, shortest, cnt_ext[bsst_pkg::COUNT_W-1:0], tail.store};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// count at the head never exceeds the store
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		EXT_W'(held_q) <= MAX_C)
		else $error("held count beyond store depth");

	// the minimum gap only ever shrinks
	a_gap_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> gap_q <= $past(gap_q))
		else $error("smallest gap grew");

	// under two values both spans read zero
	a_small_spans: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[7:1] < 7'd2) && (MAX_ENTRIES < 128))
		|-> (m_axis_tdata[71:8] == '0))
		else $error("span reported with fewer than two values");

	// a stored value leaves a nonzero count behind
	a_accept_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[0] && (MAX_ENTRIES < 128))
		|-> (m_axis_tdata[7:1] != '0))
		else $error("accepted value with empty count");

endmodule

// File: sv/bsst_cell.sv
// one cell of the sorted-free span chain: holds one stored value and
// folds its distance to a passing value into the running minimum gap
// depends on bsst_pkg
module bsst_cell #(
	parameter int CNT_W = 7,
	parameter int POS   = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  bsst_pkg::token_t     tok_in,
	input  logic [CNT_W-1:0]     idx_in,
	output bsst_pkg::token_t     tok_out,
	output logic [CNT_W-1:0]     idx_out
);

	localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);

	logic [bsst_pkg::DATA_W-1:0] entry_q;
	bsst_pkg::token_t            tok_q;
	logic [CNT_W-1:0]            idx_q;
	logic [bsst_pkg::GAP_W-1:0]  diff;
	logic [bsst_pkg::GAP_W-1:0]  mag;
	logic                        cmp_en;
	bsst_pkg::token_t            tok_nxt;

	// signed difference in 33 bits, magnitude always fits 32
	always_comb begin
		diff = {tok_in.value[bsst_pkg::DATA_W-1], tok_in.value}
			- {entry_q[bsst_pkg::DATA_W-1], entry_q};
		mag = diff[bsst_pkg::GAP_W-1] ? (~diff + 1'b1) : diff;
		cmp_en = tok_in.vld && tok_in.store && (POS_C < idx_in);
		tok_nxt = tok_in;
		if (cmp_en && (mag < tok_in.gap)) begin
			tok_nxt.gap = mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (en) begin
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_q <= idx_in;
			if (tok_in.vld && tok_in.store && (idx_in == POS_C)) begin
				entry_q <= tok_in.value;
			end
		end
	end

	assign tok_out = tok_q;
	assign idx_out = idx_q;

endmodule

// File: tb/sv/bounded_set_span_tracker_test.sv
// self-checking testbench for bounded_set_span_tracker: directed and random values,
// capacity changes between phases, random stalls on both streams, one long output hold
// depends on bsst_pkg and bounded_set_span_tracker
module bounded_set_span_tracker_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 64;
	localparam int PIPE_CYCLES = STORE_DEPTH + 1;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 250;
	localparam int PRINT_LIMIT = 50;
	localparam logic [bsst_pkg::DATA_W-1:0] VALUE_MIN = 32'h8000_0000;
	localparam logic [bsst_pkg::DATA_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
	localparam logic [bsst_pkg::DATA_W-1:0] SIGN_BIT = 32'h8000_0000;

	typedef struct packed {
		logic                         accepted;
		logic [bsst_pkg::COUNT_W-1:0] count;
		logic [bsst_pkg::DATA_W-1:0]  shortest;
		logic [bsst_pkg::DATA_W-1:0]  longest;
	} span_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        capacity_we = 1'b0;
	logic [6:0]  capacity = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [31:0] value
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;        // [0] accepted, [7:1] stored_count,
	                                  // [39:8] shortest_span, [71:40] longest_span

	// mirror of the store
	logic [bsst_pkg::DATA_W-1:0] kept_values [STORE_DEPTH];
	int                          held_count = 0;
	logic [bsst_pkg::DATA_W-1:0] least_kept = '0;
	logic [bsst_pkg::DATA_W-1:0] greatest_kept = '0;
	logic [bsst_pkg::GAP_W-1:0]  narrowest_gap = bsst_pkg::GAP_NONE;
	int                          capacity_setting = 0;

	logic [bsst_pkg::DATA_W-1:0] pending_values [$];
	span_report_t                expected_spans [$];
	logic [bsst_pkg::DATA_W-1:0] cluster_center = '0;
	int                          taken_total = 0;
	int                          fail_count = 0;
	int                          hold_left = 0;
	bit                          hold_done = 1'b0;
	int                          idle_cycles = 0;

	wire calm = taken_total >= 200 && taken_total < 280;

	bounded_set_span_tracker #(.MAX_ENTRIES(STORE_DEPTH)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.capacity_we   (capacity_we),
		.capacity      (capacity),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// flipping the sign bit turns signed order into unsigned order
	function automatic logic [bsst_pkg::GAP_W-1:0] order_key(
		input logic [bsst_pkg::DATA_W-1:0] v);
		return {1'b0, v ^ SIGN_BIT};
	endfunction

	function automatic span_report_t track_value(input logic [bsst_pkg::DATA_W-1:0] v);
		span_report_t r;
		int bound;
		logic [bsst_pkg::GAP_W-1:0] ka;
		logic [bsst_pkg::GAP_W-1:0] kb;
		logic [bsst_pkg::GAP_W-1:0] g;
		bound = (capacity_setting > STORE_DEPTH) ? STORE_DEPTH : capacity_setting;
		r = '0;
		if (held_count < bound) begin
			if (held_count == 0) begin
				least_kept = v;
				greatest_kept = v;
			end else begin
				ka = order_key(v);
				for (int i = 0; i < held_count; i++) begin
					kb = order_key(kept_values[i]);
					g = (ka >= kb) ? ka - kb : kb - ka;
					if (g < narrowest_gap)
						narrowest_gap = g;
				end
				if (ka < order_key(least_kept))
					least_kept = v;
				if (ka > order_key(greatest_kept))
					greatest_kept = v;
			end
			kept_values[held_count] = v;
			held_count++;
			r.accepted = 1'b1;
		end
		r.count = held_count[bsst_pkg::COUNT_W-1:0];
		if (held_count >= 2) begin
			r.shortest = narrowest_gap[bsst_pkg::DATA_W-1:0];
			g = order_key(greatest_kept) - order_key(least_kept);
			r.longest = g[bsst_pkg::DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [bsst_pkg::DATA_W-1:0] pick_value();
		int unsigned sel;
		logic [bsst_pkg::DATA_W-1:0] v;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			v = $urandom;
		end else if (sel < 9) begin
			v = cluster_center + $urandom_range(0, 4095) - 32'd2048;
		end else begin
			case ($urandom_range(0, 3))
				0: v = VALUE_MIN;
				1: v = VALUE_MAX;
				2: v = '0;
				default: v = '1;
			endcase
		end
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < PRINT_LIMIT)
			$display("error at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic enqueue_value(input logic [bsst_pkg::DATA_W-1:0] v);
		pending_values.insert(pending_values.size(), v);
	endtask

	// register writes happen only with nothing in flight
	task automatic set_capacity(input int c);
		@(posedge clk);
		capacity_we <= 1'b1;
		capacity <= c[6:0];
		capacity_setting = c;
		@(posedge clk);
		capacity_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_block();
		while (pending_values.size() != 0 || s_axis_tvalid || expected_spans.size() != 0)
			@(negedge clk);
		repeat (PIPE_CYCLES + 15) @(negedge clk);
	endtask

	task automatic queue_random(input int n);
		cluster_center = $urandom;
		repeat (n) enqueue_value(pick_value());
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_values.size() != 0 && (calm || $urandom_range(0, 99) >= 6)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_values.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold so the chain fills and backs up the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && taken_total >= 20) begin
			m_axis_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			m_axis_tready <= calm || $urandom_range(0, 99) >= 6;
		end
	end

	// monitor: predict on input transactions, check on output transactions
	always @(posedge clk) begin
		span_report_t want;
		span_report_t got;
		span_report_t pred;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				pred = track_value(s_axis_tdata);
				expected_spans.insert(expected_spans.size(), pred);
				taken_total <= taken_total + 1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.accepted = m_axis_tdata[0];
				got.count = m_axis_tdata[7:1];
				got.shortest = m_axis_tdata[39:8];
				got.longest = m_axis_tdata[71:40];
				if (expected_spans.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: %h", m_axis_tdata));
				end else begin
					want = expected_spans.pop_front();
					if (got.accepted !== want.accepted)
						report_mismatch($sformatf("accepted %b, expected %b",
							got.accepted, want.accepted));
					if (got.count !== want.count)
						report_mismatch($sformatf("stored_count %0d, expected %0d",
							got.count, want.count));
					if (got.shortest !== want.shortest)
						report_mismatch($sformatf("shortest_span %h, expected %h",
							got.shortest, want.shortest));
					if (got.longest !== want.longest)
						report_mismatch($sformatf("longest_span %h, expected %h",
							got.longest, want.longest));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", idle_cycles);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty capacity rejects everything, extremes included
		set_capacity(0);
		enqueue_value(VALUE_MIN);
		enqueue_value(VALUE_MAX);
		enqueue_value('0);
		enqueue_value('1);
		drain_block();

		// single entry: spans stay zero
		set_capacity(1);
		enqueue_value(32'd100);
		enqueue_value(-32'sd7);
		drain_block();

		set_capacity(2);
		enqueue_value(-32'sd7);
		enqueue_value(32'd55);
		drain_block();

		// random phases with capacity a few above the count; the first one is long
		// enough for the output hold to back up the input
		for (int p = 0; p < 8; p++) begin
			set_capacity(held_count + $urandom_range(1, 6));
			queue_random(p == 0 ? 120 : 25);
			drain_block();
		end

		// capacity below the count: held values stay, new ones are refused
		set_capacity(held_count >= 2 ? held_count - 2 : 0);
		queue_random(20);
		drain_block();

		set_capacity(STORE_DEPTH);
		queue_random(20);
		drain_block();

		// capacity above the store depth, extremes and a repeated value
		set_capacity(127);
		enqueue_value(VALUE_MIN);
		enqueue_value(VALUE_MAX);
		enqueue_value(kept_values[0]);
		queue_random(60);
		drain_block();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
sv/bsst_pkg.sv
sv/bsst_cell.sv
sv/bounded_set_span_tracker.sv
tb/sv/bounded_set_span_tracker_test.sv
